// ===== hdl/sspk_pkg.sv =====
// Shared types and constants for the scope sample frame packer.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package sspk_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CNT_W     = 6;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [CNT_W-1:0] MAX_USE_RESET = 6'd30;
    localparam logic [CNT_W-1:0] CNT_SAT       = 6'd63;

    // Output tdata layout
    localparam int OUT_CH_LSB  = 0;
    localparam int OUT_PT_LSB  = 6;
    localparam int OUT_DW_LSB  = 12;
    localparam int OUT_USED_W  = 28;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_LD   = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

endpackage

// ===== hdl/sspk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the frame buffer of the packer.
`timescale 1ns / 1ps

module sspk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/scope_sample_frame_packer.sv =====
// Scope sample frame packer: top level with frame state and drain sequencer.
// Depends on sspk_pkg and sspk_ram (frame word buffer).
//
// Channel   Dir  Payload
// s_axis    in   tdata = sample[15:0], set_size[21:16]; tlast = last_in_set
// m_axis    out  tdata = frame_channels[5:0], frame_points[11:6], data_word[27:12];
//                tuser = has_data; tlast = last
// cfg       in   i_cfg_wdata = max_use, written when i_cfg_we is high
//
// An input request is taken while no frame is draining.
// A frame drain issues the first buffer read (S_RD), then for each stored word steps
// through S_LD (buffer read data into the output register) and S_OUT (held through m_axis stalls);
// an empty frame goes straight to S_OUT. Intake waits until the final result is taken.
// Reset (synchronous, active low) closes the frame; buffer contents are not cleared.
`timescale 1ns / 1ps

module scope_sample_frame_packer
    import sspk_pkg::*;
#(
    parameter int MAX_WORDS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CNT_W-1:0]     i_cfg_wdata,     // max_use
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,  // sample[15:0], set_size[21:16]
    input  logic                 i_s_axis_tlast,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,  // channels[5:0], points[11:6], word[27:12]
    output logic                 o_m_axis_tuser,  // has_data
    output logic                 o_m_axis_tlast
);

    localparam int AW    = $clog2(MAX_WORDS);
    localparam int CW    = $clog2(MAX_WORDS + 1);
    localparam int SUM_W = ((CW > CNT_W) ? CW : CNT_W) + 1;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_max_use;
    logic [CW-1:0]       r_fill;
    logic [CNT_W-1:0]    r_pts;
    logic [CNT_W-1:0]    r_chan;
    logic                r_open;
    logic [CNT_W-1:0]    r_set_idx;
    logic                r_set_fits;
    logic [CNT_W-1:0]    r_set_len;
    logic [CW-1:0]       r_drain_len;
    logic [AW-1:0]       r_rd_addr;
    logic [SAMPLE_W-1:0] r_out_word;
    logic                r_out_has;
    logic                r_out_last;

    logic [SAMPLE_W-1:0] in_sample;
    logic [CNT_W-1:0]    in_size;
    logic                acc;
    logic                first;
    logic                fresh;
    logic [SUM_W-1:0]    cap;
    logic [SUM_W-1:0]    max_ext;
    logic [CW-1:0]       fill_eff;
    logic [CNT_W-1:0]    pts_base;
    logic [CNT_W-1:0]    len_eff;
    logic                fits_eff;
    logic [SUM_W-1:0]    wsum;
    logic [CNT_W-1:0]    idx_inc;
    logic [CNT_W-1:0]    stored;
    logic [SUM_W-1:0]    fill_end;
    logic [CNT_W-1:0]    pts_end;
    logic                emit;
    logic                ram_we;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic                out_take;

    assign in_sample = i_s_axis_tdata[SAMPLE_W-1:0];
    assign in_size   = i_s_axis_tdata[SAMPLE_W +: CNT_W];
    assign acc       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_take  = (r_state == S_OUT) && i_m_axis_tready;

    assign max_ext = SUM_W'(r_max_use);
    assign cap     = (max_ext < SUM_W'(MAX_WORDS)) ? max_ext : SUM_W'(MAX_WORDS);

    assign first    = (r_set_idx == '0);
    assign fresh    = first && !r_open;
    assign fill_eff = fresh ? '0 : r_fill;
    assign pts_base = fresh ? '0 : r_pts;
    assign len_eff  = first ? in_size : r_set_len;
    assign fits_eff = first ? (SUM_W'(fill_eff) + SUM_W'(in_size) <= cap) : r_set_fits;

    assign wsum    = SUM_W'(fill_eff) + SUM_W'(r_set_idx);
    assign ram_we  = acc && fits_eff && (r_set_idx < len_eff);

    assign idx_inc  = (r_set_idx != CNT_SAT) ? r_set_idx + 1'b1 : r_set_idx;
    assign stored   = (idx_inc < len_eff) ? idx_inc : len_eff;
    assign fill_end = fits_eff ? SUM_W'(fill_eff) + SUM_W'(stored) : SUM_W'(fill_eff);
    assign pts_end  = (fits_eff && pts_base != CNT_SAT) ? pts_base + 1'b1 : pts_base;
    assign emit     = i_s_axis_tlast && (fill_end + SUM_W'(len_eff) > cap);

    assign ram_re    = (r_state == S_RD) || (out_take && !r_out_last);
    assign ram_raddr = (r_state == S_OUT) ? r_rd_addr + 1'b1 : r_rd_addr;

    sspk_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wsum[AW-1:0]),
        .i_wdata (in_sample),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc && emit) begin
                    n_state = (fill_end == '0) ? S_OUT : S_RD;
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_m_axis_tready) begin
                    n_state = r_out_last ? S_IDLE : S_LD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_max_use  <= MAX_USE_RESET;
            r_fill     <= '0;
            r_pts      <= '0;
            r_chan     <= '0;
            r_open     <= 1'b0;
            r_set_idx  <= '0;
            r_set_fits <= 1'b0;
            r_set_len  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_max_use <= i_cfg_wdata;
            end
            if (acc) begin
                if (fresh) begin
                    r_chan <= in_size;
                end
                if (first) begin
                    r_set_len <= in_size;
                end
                if (!i_s_axis_tlast) begin
                    r_open     <= 1'b1;
                    r_set_idx  <= idx_inc;
                    r_set_fits <= fits_eff;
                    r_fill     <= fill_eff;
                    r_pts      <= pts_base;
                end else begin
                    r_set_idx  <= '0;
                    r_set_fits <= 1'b0;
                    r_pts      <= pts_end;
                    if (emit) begin
                        r_open <= 1'b0;
                        r_fill <= '0;
                    end else begin
                        r_open <= 1'b1;
                        r_fill <= fill_end[CW-1:0];
                    end
                end
            end
        end
    end

    // Drain payload
    always_ff @(posedge i_clk) begin
        if (acc && emit) begin
            r_drain_len <= fill_end[CW-1:0];
            r_rd_addr   <= '0;
            r_out_word  <= '0;
            r_out_has   <= 1'b0;
            r_out_last  <= 1'b1;
        end
        if (r_state == S_LD) begin
            r_out_word <= ram_rdata;
            r_out_has  <= 1'b1;
            r_out_last <= (SUM_W'(r_rd_addr) + 1'b1 == SUM_W'(r_drain_len));
        end
        if (out_take && !r_out_last) begin
            r_rd_addr <= r_rd_addr + 1'b1;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = M_TDATA_W'({r_out_word, r_pts, r_chan});
    assign o_m_axis_tuser  = r_out_has;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== hdl/sspk_checker.sv =====
// Port-level checker for the scope sample frame packer, bound to the top level.
// Depends on sspk_pkg.
`timescale 1ns / 1ps

module sspk_checker
    import sspk_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input logic                 o_m_axis_tuser,
    input logic                 o_m_axis_tlast
);

    // No intake while a frame is draining
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("intake open during frame drain");

    // Empty frame result is a single, last, zero word
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |->
            (o_m_axis_tlast && o_m_axis_tdata[OUT_DW_LSB +: SAMPLE_W] == '0))
        else $error("empty frame result malformed");

    // Frame header fields hold for the whole run
    a_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=>
            ##1 (o_m_axis_tdata[OUT_DW_LSB-1:0] == $past(o_m_axis_tdata[OUT_DW_LSB-1:0], 2)))
        else $error("frame header changed within run");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind scope_sample_frame_packer sspk_checker u_sspk_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// ===== sim/scope_sample_frame_packer_tb.sv =====
// Self-checking testbench for scope_sample_frame_packer.
// Depends on sspk_pkg and the packer RTL. A frame predictor checks every output
// beat, with random gaps on both stream sides.
`timescale 1ns / 1ps

module scope_sample_frame_packer_tb;
    import sspk_pkg::*;

    localparam int MAX_WORDS   = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 8;

    typedef struct {
        logic [CNT_W-1:0]    channels;
        logic [CNT_W-1:0]    points;
        logic [SAMPLE_W-1:0] word;
        logic                has_data;
        logic                last;
    } t_frame_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CNT_W-1:0]     i_cfg_wdata;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata;
    logic                 i_s_axis_tlast;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic                 o_m_axis_tuser;
    logic                 o_m_axis_tlast;

    t_frame_beat pending_beats[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          quiet = 1'b0;

    // predicted packer state
    logic [SAMPLE_W-1:0] pk_words [MAX_WORDS];
    int                  pk_fill, pk_points, pk_chans, pk_idx, pk_len;
    int                  pk_max_use = MAX_USE_RESET;
    bit                  pk_open, pk_fits;

    scope_sample_frame_packer #(
        .MAX_WORDS(MAX_WORDS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void pack_sample(input logic [SAMPLE_W-1:0] sample, input int size,
                                        input bit last_in);
        int          cap;
        int          i;
        t_frame_beat beat;
        cap = (pk_max_use < MAX_WORDS) ? pk_max_use : MAX_WORDS;
        if (pk_idx == 0) begin
            if (!pk_open) begin
                pk_open   = 1'b1;
                pk_fill   = 0;
                pk_chans  = size;
                pk_points = 0;
            end
            pk_len  = size;
            pk_fits = (pk_fill + pk_len <= cap);
        end
        if (pk_fits && pk_idx < pk_len && pk_fill + pk_idx < MAX_WORDS)
            pk_words[pk_fill + pk_idx] = sample;
        if (pk_idx < 63)
            pk_idx++;
        if (!last_in)
            return;
        if (pk_fits) begin
            pk_fill += (pk_idx < pk_len) ? pk_idx : pk_len;
            if (pk_points < 63)
                pk_points++;
        end
        pk_idx  = 0;
        pk_fits = 1'b0;
        if (pk_fill + pk_len > cap) begin
            beat.channels = CNT_W'(pk_chans);
            beat.points   = CNT_W'(pk_points);
            if (pk_fill == 0) begin
                beat.word     = '0;
                beat.has_data = 1'b0;
                beat.last     = 1'b1;
                pending_beats.push_back(beat);
            end else begin
                for (i = 0; i < pk_fill && i < MAX_WORDS; i++) begin
                    beat.word     = pk_words[i];
                    beat.has_data = 1'b1;
                    beat.last     = (i + 1 == pk_fill);
                    pending_beats.push_back(beat);
                end
            end
            pk_open = 1'b0;
            pk_fill = 0;
        end
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    endtask

    // one request on the sample stream; valid stays high across back-to-back requests
    task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input logic [CNT_W-1:0] size,
                               input bit last_in);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, size, sample};
        i_s_axis_tlast  <= last_in;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        pack_sample(sample, int'(size), last_in);
    endtask

    // size goes on the first word only; later words carry junk in the size field
    task automatic send_set(input int size, input int n_words);
        for (int k = 0; k < n_words; k++)
            send_sample(SAMPLE_W'($urandom),
                        (k == 0) ? CNT_W'(size) : CNT_W'($urandom_range(0, 63)),
                        k == n_words - 1);
    endtask

    task automatic drain_frames();
        i_s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_max_use(input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CNT_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pk_max_use = value;
    endtask

    always @(posedge i_clk) begin : result_check
        t_frame_beat want;
        if (i_rst_n === 1'b1 && o_m_axis_tvalid === 1'b1 && i_m_axis_tready === 1'b1) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected beat", o_m_axis_tdata, 0);
            end else begin
                want = pending_beats.pop_front();
                if (o_m_axis_tdata[OUT_CH_LSB +: CNT_W] !== want.channels)
                    report_mismatch("frame_channels", o_m_axis_tdata[OUT_CH_LSB +: CNT_W],
                                    want.channels);
                if (o_m_axis_tdata[OUT_PT_LSB +: CNT_W] !== want.points)
                    report_mismatch("frame_points", o_m_axis_tdata[OUT_PT_LSB +: CNT_W],
                                    want.points);
                if (o_m_axis_tdata[OUT_DW_LSB +: SAMPLE_W] !== want.word)
                    report_mismatch("data_word", o_m_axis_tdata[OUT_DW_LSB +: SAMPLE_W],
                                    want.word);
                if (o_m_axis_tdata[M_TDATA_W-1:OUT_USED_W] !== '0)
                    report_mismatch("tdata padding", o_m_axis_tdata[M_TDATA_W-1:OUT_USED_W], 0);
                if (o_m_axis_tuser !== want.has_data)
                    report_mismatch("has_data", o_m_axis_tuser, want.has_data);
                if (o_m_axis_tlast !== want.last)
                    report_mismatch("last", o_m_axis_tlast, want.last);
            end
        end
    end

    // result side: random stall before each beat
    initial begin
        int gap;
        i_m_axis_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
        end
    end

    // reset capacity is 30, so a 31-word set cannot fit: empty frame
    task automatic test_reset_capacity();
        send_set(31, 1);
        drain_frames();
    endtask

    // capacity 1, extreme samples, and a zero-size set opening a frame
    task automatic test_min_capacity();
        write_max_use(1);
        send_sample(16'hFFFF, 6'd1, 1'b1);
        send_sample(16'h0000, 6'd0, 1'b1);
        send_sample(16'h0000, 6'd1, 1'b1);
        drain_frames();
    endtask

    // max_use above the buffer size acts as 32; short set, extra words, oversized set
    task automatic test_oversized_register();
        write_max_use(63);
        send_set(32, 2);
        send_set(2, 4);
        send_sample(16'hA5A5, 6'd63, 1'b1);
        drain_frames();
    endtask

    task automatic test_capacity_lowered();
        write_max_use(8);
        send_set(4, 4);
        drain_frames();
        write_max_use(5);
        send_set(4, 1);
        drain_frames();
    endtask

    // point count saturates at 63
    task automatic test_counter_limits();
        write_max_use(32);
        repeat (64) send_sample(SAMPLE_W'($urandom), 6'd0, 1'b1);
        send_set(3, 3);
        send_set(40, 1);
        drain_frames();
    endtask

    task automatic test_random_frames();
        int setting[5];
        int cap, size, words, sent;
        setting[0] = 3;
        setting[1] = 32;
        setting[2] = 1;
        setting[3] = $urandom_range(2, 31);
        setting[4] = $urandom_range(33, 63);
        for (int ph = 0; ph < 5; ph++) begin
            drain_frames();
            write_max_use(setting[ph]);
            quiet = (ph == 1);
            sent = 0;
            while (sent < 5) begin
                cap  = (pk_max_use < MAX_WORDS) ? pk_max_use : MAX_WORDS;
                size = $urandom_range(1, (cap < 6) ? cap : 6);
                case ($urandom_range(0, 9))
                    0: begin
                        words = $urandom_range(1, 2);
                        send_set(0, words);
                    end
                    1: begin
                        size  = $urandom_range(2, (cap < 2) ? 2 : cap);
                        words = $urandom_range(1, size - 1);
                        send_set(size, words);
                    end
                    2: begin
                        words = size + $urandom_range(1, 3);
                        send_set(size, words);
                    end
                    3: begin
                        words = $urandom_range(1, 2);
                        send_set($urandom_range(cap + 1, 63), words);
                    end
                    default: begin
                        words = size;
                        send_set(size, words);
                    end
                endcase
                sent += words;
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        pk_fill   = 0;
        pk_points = 0;
        pk_chans  = 0;
        pk_idx    = 0;
        pk_len    = 0;
        pk_open   = 1'b0;
        pk_fits   = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_capacity();
        test_min_capacity();
        test_oversized_register();
        test_capacity_lowered();
        test_counter_limits();
        test_random_frames();
        drain_frames();

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
